// ===== sv/cslo_pkg.sv =====
// Package for the clock sync level offset engine: constants, opcodes and the
// word, state and result types shared by the step logic and the top level.
// No dependencies.
`default_nettype none
package cslo_pkg;

  localparam int PEER_SLOTS = 16;
  localparam logic [7:0] LEADER_LEVEL = 8'd0;
  localparam logic [7:0] UNSYNCED_LEVEL = 8'd255;
  localparam logic [7:0] LEVEL_LIMIT = 8'd254;
  localparam logic [15:0] SYNC_INTERVAL_RESET = 16'd5000;

  localparam logic [1:0] OP_SYNC_START = 2'd0;
  localparam logic [1:0] OP_DELAY_RESPONSE = 2'd1;
  localparam logic [1:0] OP_LEADER = 2'd2;
  localparam logic [1:0] OP_TIME_QUERY = 2'd3;

  localparam logic [3:0] ADDR_CLOCK_START = 4'd0;
  localparam logic [3:0] ADDR_SYNC_INTERVAL = 4'd8;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [62:0] now_ms;
    logic [62:0] send_ms;
    logic [63:0] remote_timestamp;
    logic [7:0]  sender_level;
    logic        peer_known;
    logic [3:0]  peer_index;
  } item_t;

  typedef struct packed {
    logic [62:0] clock_start_ms;
    logic [15:0] sync_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  node_level;
    logic [63:0] clock_offset;
    logic        round_active;
    logic [63:0] req_sent_ms;
    logic [63:0] partial_offset;
    logic [7:0]  round_peer_level;
    logic [3:0]  round_peer;
    logic [3:0]  synced_peer;
    logic        synced_peer_valid;
  } state_t;

  typedef struct packed {
    logic        status;
    logic        send_delay_request;
    logic [7:0]  level_out;
    logic [63:0] time_out;
    logic [63:0] offset_out;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/cslo_step.sv =====
// Step logic of the clock sync level offset engine: applies one word to the
// engine state and forms its result. Combinational; depends on cslo_pkg.
`default_nettype none
module cslo_step (
  input  cslo_pkg::item_t   item_i,
  input  cslo_pkg::cfg_t    cfg_i,
  input  cslo_pkg::state_t  state_i,
  output cslo_pkg::state_t  state_o,
  output cslo_pkg::result_t result_o
);
  import cslo_pkg::*;

  logic [63:0] now_ext;
  logic [63:0] snd_ext;
  logic [63:0] start_ext;
  logic [63:0] interval_ext;
  logic [63:0] elapsed;
  logic [63:0] now_rel;
  logic [63:0] snd_rel;
  logic [63:0] full_offset;
  logic [63:0] half_offset;
  logic [8:0]  lvl_plus1;
  logic        busy;
  logic        bad_sender;
  logic        same_peer;
  logic        level_reject;
  logic        level_drop;

  always_comb begin
    now_ext      = {1'b0, item_i.now_ms};
    snd_ext      = {1'b0, item_i.send_ms};
    start_ext    = {1'b0, cfg_i.clock_start_ms};
    interval_ext = {48'd0, cfg_i.sync_interval_ms};
    elapsed      = now_ext - state_i.req_sent_ms;
    now_rel      = now_ext - start_ext;
    snd_rel      = snd_ext - start_ext;
    full_offset  = state_i.partial_offset - item_i.remote_timestamp;
    half_offset  = 64'($signed(full_offset + {63'd0, full_offset[63]}) >>> 1);
    lvl_plus1    = {1'b0, item_i.sender_level} + 9'd1;
    busy         = state_i.round_active && (elapsed < interval_ext);
    bad_sender   = (item_i.sender_level >= LEVEL_LIMIT) || !item_i.peer_known ||
                   ({5'd0, item_i.peer_index} >= 9'(PEER_SLOTS));
    same_peer    = (state_i.node_level < UNSYNCED_LEVEL) &&
                   (state_i.node_level != LEADER_LEVEL) &&
                   state_i.synced_peer_valid &&
                   (state_i.synced_peer == item_i.peer_index);
    level_drop   = same_peer && (state_i.node_level <= item_i.sender_level);
    level_reject = same_peer ? level_drop : ({1'b0, state_i.node_level} <= lvl_plus1);

    state_o  = state_i;
    result_o = '0;

    case (item_i.opcode)
      OP_SYNC_START: begin
        if (busy || bad_sender) begin
          result_o.status = 1'b1;
        end else if (level_reject) begin
          result_o.status = 1'b1;
          if (level_drop) begin
            state_o.node_level = UNSYNCED_LEVEL;
          end
        end else begin
          state_o.round_active     = 1'b1;
          state_o.round_peer_level = item_i.sender_level;
          state_o.round_peer       = item_i.peer_index;
          state_o.partial_offset   = now_rel - item_i.remote_timestamp + snd_rel;
          state_o.req_sent_ms      = snd_ext;
          result_o.send_delay_request = 1'b1;
        end
      end
      OP_DELAY_RESPONSE: begin
        if (!state_i.round_active) begin
          result_o.status = 1'b1;
        end else if ((elapsed > interval_ext) ||
                     (state_i.round_peer_level != item_i.sender_level)) begin
          result_o.status      = 1'b1;
          state_o.round_active = 1'b0;
        end else begin
          state_o.clock_offset      = half_offset;
          state_o.partial_offset    = '0;
          state_o.node_level        = lvl_plus1[7:0];
          state_o.synced_peer       = state_i.round_peer;
          state_o.synced_peer_valid = 1'b1;
          state_o.round_active      = 1'b0;
        end
      end
      OP_LEADER: begin
        if (item_i.sender_level == LEADER_LEVEL) begin
          state_o.node_level   = LEADER_LEVEL;
          state_o.clock_offset = '0;
        end else if ((item_i.sender_level == UNSYNCED_LEVEL) &&
                     (state_i.node_level == LEADER_LEVEL)) begin
          state_o.node_level = UNSYNCED_LEVEL;
        end else begin
          result_o.status = 1'b1;
        end
      end
      OP_TIME_QUERY: begin
        if (state_i.node_level != UNSYNCED_LEVEL) begin
          result_o.time_out = now_rel - state_i.clock_offset;
        end else begin
          result_o.time_out = now_rel;
        end
      end
      default: begin
        result_o.status = 1'b1;
      end
    endcase

    result_o.level_out  = state_o.node_level;
    result_o.offset_out = state_o.clock_offset;
  end

endmodule
`default_nettype wire

// ===== sv/clock_sync_level_offset_engine.sv =====
// Top level of the clock sync level offset engine: input register, engine
// state, result register and the APB configuration registers.
// Depends on cslo_pkg and cslo_step.
//
// Usage: message words enter on the in channel (valid/ready) and one result
// word per input word leaves on the out channel (valid/ready). A word is
// taken into an input register, processed against the engine state by a
// single pass of combinational logic and written to the result register
// together with the state update. The result word is shown from the result
// register, and throughput is one word per cycle while the receiver holds
// out_ready_i high and words keep arriving, a rate set by the single state
// update per cycle. When the receiver stalls, the result register holds and
// the input register keeps one further word, after which in_ready_o drops.
// Reset clears the pipeline, sets the node level to unsynchronized, zeroes
// offset and round state, and loads clock_start_ms with zero and
// sync_interval_ms with 5000. The APB port holds clock_start_ms at address 0
// and sync_interval_ms at address 8; pready is always high.
`default_nettype none
module clock_sync_level_offset_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [62:0]        now_ms_i,
  input  logic [62:0]        send_ms_i,
  input  logic [63:0]        remote_timestamp_i,
  input  logic [7:0]         sender_level_i,
  input  logic               peer_known_i,
  input  logic [3:0]         peer_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output logic               send_delay_request_o,
  output logic [7:0]         level_out_o,
  output logic [63:0]        time_out_o,
  output logic signed [63:0] offset_out_o
);
  import cslo_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  item_t   item_q;
  logic    item_valid_q;
  result_t result_q;
  result_t result_d;
  logic    out_valid_q;
  logic    advance;
  logic    cfg_write;

  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  always_comb begin
    case (paddr)
      ADDR_CLOCK_START:   prdata = {1'b0, cfg_q.clock_start_ms};
      ADDR_SYNC_INTERVAL: prdata = {48'd0, cfg_q.sync_interval_ms};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_start_ms   <= '0;
      cfg_q.sync_interval_ms <= SYNC_INTERVAL_RESET;
    end else if (cfg_write) begin
      if (paddr == ADDR_CLOCK_START) begin
        cfg_q.clock_start_ms <= pwdata[62:0];
      end
      if (paddr == ADDR_SYNC_INTERVAL) begin
        cfg_q.sync_interval_ms <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.opcode           <= opcode_i;
      item_q.now_ms           <= now_ms_i;
      item_q.send_ms          <= send_ms_i;
      item_q.remote_timestamp <= remote_timestamp_i;
      item_q.sender_level     <= sender_level_i;
      item_q.peer_known       <= peer_known_i;
      item_q.peer_index       <= peer_index_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  cslo_step u_step (
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q              <= 1'b0;
      out_valid_q               <= 1'b0;
      state_q.node_level        <= UNSYNCED_LEVEL;
      state_q.clock_offset      <= '0;
      state_q.round_active      <= 1'b0;
      state_q.req_sent_ms       <= '0;
      state_q.partial_offset    <= '0;
      state_q.round_peer_level  <= '0;
      state_q.round_peer        <= '0;
      state_q.synced_peer       <= '0;
      state_q.synced_peer_valid <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = result_q.status;
  assign send_delay_request_o = result_q.send_delay_request;
  assign level_out_o          = result_q.level_out;
  assign time_out_o           = result_q.time_out;
  assign offset_out_o         = $signed(result_q.offset_out);

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for clock_sync_level_offset_engine: random and directed message words
// are checked against an in-bench predictor of the sync rounds, levels, offsets and time queries.
// Depends on cslo_pkg and the engine RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cslo_pkg::*;

  localparam int TIMEOUT_CYCLES = 200000;
  localparam logic [62:0] MAX63 = '1;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         opcode_i;
  logic [62:0]        now_ms_i;
  logic [62:0]        send_ms_i;
  logic [63:0]        remote_timestamp_i;
  logic [7:0]         sender_level_i;
  logic               peer_known_i;
  logic [3:0]         peer_index_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               status_o;
  logic               send_delay_request_o;
  logic [7:0]         level_out_o;
  logic [63:0]        time_out_o;
  logic signed [63:0] offset_out_o;

  clock_sync_level_offset_engine i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .opcode_i             (opcode_i),
    .now_ms_i             (now_ms_i),
    .send_ms_i            (send_ms_i),
    .remote_timestamp_i   (remote_timestamp_i),
    .sender_level_i       (sender_level_i),
    .peer_known_i         (peer_known_i),
    .peer_index_i         (peer_index_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .status_o             (status_o),
    .send_delay_request_o (send_delay_request_o),
    .level_out_o          (level_out_o),
    .time_out_o           (time_out_o),
    .offset_out_o         (offset_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  state_t  eng;
  cfg_t    cfg;
  result_t expected_results[$];

  int          fail_count = 0;
  int          words_sent = 0;
  int          results_checked = 0;
  int          settings_used = 0;
  int          syncs_accepted = 0;
  int          rounds_closed = 0;
  int          cycle_count = 0;
  int unsigned hold_cycles = 0;
  logic        rx_hold = 1'b0;
  logic        tx_gaps = 1'b1;
  logic        rx_gaps = 1'b1;
  logic        in_valid_up = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at result word %0d, %s: got %h, expected %h",
             results_checked, what, got, want);
    fail_count++;
  endtask

  function automatic result_t predict_result(input item_t w);
    result_t     r;
    logic [63:0] now64;
    logic [63:0] start64;
    logic [63:0] since_req;
    logic [63:0] interval64;
    logic [63:0] diff;
    logic [63:0] mag;
    now64      = {1'b0, w.now_ms};
    start64    = {1'b0, cfg.clock_start_ms};
    since_req  = now64 - eng.req_sent_ms;
    interval64 = {48'd0, cfg.sync_interval_ms};
    r = '0;
    case (w.opcode)
      OP_SYNC_START: begin
        if (eng.round_active && since_req < interval64) begin
          r.status = 1'b1;
        end else if (w.sender_level >= LEVEL_LIMIT || !w.peer_known) begin
          r.status = 1'b1;
        end else begin
          if (eng.node_level != UNSYNCED_LEVEL && eng.node_level != LEADER_LEVEL &&
              eng.synced_peer_valid && eng.synced_peer == w.peer_index) begin
            if (eng.node_level <= w.sender_level) begin
              eng.node_level = UNSYNCED_LEVEL;
              r.status = 1'b1;
            end
          end else if ({1'b0, eng.node_level} <= {1'b0, w.sender_level} + 9'd1) begin
            r.status = 1'b1;
          end
          if (!r.status) begin
            eng.round_active     = 1'b1;
            eng.round_peer_level = w.sender_level;
            eng.round_peer       = w.peer_index;
            eng.partial_offset   = (now64 - start64) - w.remote_timestamp +
                                   ({1'b0, w.send_ms} - start64);
            eng.req_sent_ms      = {1'b0, w.send_ms};
            r.send_delay_request = 1'b1;
            syncs_accepted++;
          end
        end
      end
      OP_DELAY_RESPONSE: begin
        if (!eng.round_active) begin
          r.status = 1'b1;
        end else if (since_req > interval64 || eng.round_peer_level != w.sender_level) begin
          r.status = 1'b1;
          eng.round_active = 1'b0;
        end else begin
          // Halve the signed difference, rounding toward zero.
          diff = eng.partial_offset - w.remote_timestamp;
          if (diff[63]) begin
            mag = (64'd0 - diff) >> 1;
            eng.clock_offset = 64'd0 - mag;
          end else begin
            eng.clock_offset = diff >> 1;
          end
          eng.partial_offset    = '0;
          eng.node_level        = w.sender_level + 8'd1;
          eng.synced_peer       = eng.round_peer;
          eng.synced_peer_valid = 1'b1;
          eng.round_active      = 1'b0;
          rounds_closed++;
        end
      end
      OP_LEADER: begin
        if (w.sender_level == LEADER_LEVEL) begin
          eng.node_level   = LEADER_LEVEL;
          eng.clock_offset = '0;
        end else if (w.sender_level == UNSYNCED_LEVEL && eng.node_level == LEADER_LEVEL) begin
          eng.node_level = UNSYNCED_LEVEL;
        end else begin
          r.status = 1'b1;
        end
      end
      default: begin
        r.time_out = now64 - start64;
        if (eng.node_level != UNSYNCED_LEVEL) begin
          r.time_out = r.time_out - eng.clock_offset;
        end
      end
    endcase
    r.level_out  = eng.node_level;
    r.offset_out = eng.clock_offset;
    return r;
  endfunction

  function automatic logic [62:0] pick_time();
    logic [63:0] v;
    case ($urandom_range(0, 3))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 100000));
      2: v = {1'b0, MAX63} - 64'($urandom_range(0, 100000));
      default: v = {1'b0, cfg.clock_start_ms} + 64'($urandom_range(0, 100000));
    endcase
    return v[62:0];
  endfunction

  function automatic item_t mk_word(input logic [1:0] op, input logic [62:0] now,
                                    input logic [62:0] snd, input logic [63:0] remote,
                                    input logic [7:0] lvl, input logic known,
                                    input logic [3:0] peer);
    item_t w;
    w.opcode           = op;
    w.now_ms           = now;
    w.send_ms          = snd;
    w.remote_timestamp = remote;
    w.sender_level     = lvl;
    w.peer_known       = known;
    w.peer_index       = peer;
    return w;
  endfunction

  // Mostly well-formed rounds driven from the predicted engine state, plus noise.
  function automatic item_t gen_word();
    item_t       w;
    logic [63:0] t;
    int unsigned kind;
    int unsigned span;
    w.opcode           = OP_TIME_QUERY;
    w.now_ms           = pick_time();
    w.send_ms          = pick_time();
    w.remote_timestamp = {$urandom, $urandom};
    w.sender_level     = 8'($urandom);
    w.peer_known       = 1'($urandom);
    w.peer_index       = 4'($urandom);
    span = 32'(cfg.sync_interval_ms);
    kind = $urandom_range(0, 99);
    if (eng.round_active && kind < 70) begin
      w.opcode = OP_DELAY_RESPONSE;
      if ($urandom_range(0, 9) != 0) w.sender_level = eng.round_peer_level;
      if ($urandom_range(0, 6) != 0) t = eng.req_sent_ms + 64'($urandom_range(0, span));
      else t = eng.req_sent_ms + 64'(span + 1 + $urandom_range(0, 100));
      w.now_ms = t[62:0];
      if ($urandom_range(0, 1) != 0) begin
        w.remote_timestamp = eng.req_sent_ms + 64'($urandom_range(0, 1000));
      end
    end else begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        w.opcode     = OP_SYNC_START;
        w.peer_known = ($urandom_range(0, 19) != 0);
        if (eng.synced_peer_valid && $urandom_range(0, 2) == 0) w.peer_index = eng.synced_peer;
        if (eng.node_level == UNSYNCED_LEVEL || eng.node_level == LEADER_LEVEL) begin
          w.sender_level = 8'($urandom_range(0, LEVEL_LIMIT - 1));
        end else if (eng.synced_peer_valid && w.peer_index == eng.synced_peer) begin
          w.sender_level = 8'($urandom_range(0, eng.node_level));
        end else begin
          w.sender_level = 8'($urandom_range(0, eng.node_level - 1));
        end
        if ($urandom_range(0, 7) == 0) w.sender_level = 8'($urandom);
        if (eng.round_active) t = eng.req_sent_ms + 64'($urandom_range(0, 2 * span + 2));
        else t = {1'b0, pick_time()};
        w.now_ms = t[62:0];
        t = t + 64'($urandom_range(0, 200));
        w.send_ms = t[62:0];
        if ($urandom_range(0, 1) != 0) begin
          w.remote_timestamp = {1'b0, w.now_ms} - 64'($urandom_range(0, 1000));
        end
      end else if (kind < 70) begin
        w.opcode = OP_TIME_QUERY;
      end else if (kind < 82) begin
        w.opcode = OP_LEADER;
        kind = $urandom_range(0, 3);
        if (eng.node_level == LEADER_LEVEL) begin
          if (kind != 0) w.sender_level = UNSYNCED_LEVEL;
        end else if (kind == 0) begin
          w.sender_level = LEADER_LEVEL;
        end else if (kind < 3) begin
          w.sender_level = UNSYNCED_LEVEL;
        end
      end else begin
        w.opcode = 2'($urandom);
      end
    end
    return w;
  endfunction

  task automatic send_word(input item_t w);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      if (in_valid_up) in_valid_i <= 1'b0;
      in_valid_up = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_valid_up        = 1'b1;
    opcode_i           <= w.opcode;
    now_ms_i           <= w.now_ms;
    send_ms_i          <= w.send_ms;
    remote_timestamp_i <= w.remote_timestamp;
    sender_level_i     <= w.sender_level;
    peer_known_i       <= w.peer_known;
    peer_index_i       <= w.peer_index;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_result(w));
    words_sent++;
  endtask

  task automatic wait_drained();
    if (in_valid_up) begin
      in_valid_i <= 1'b0;
      in_valid_up = 1'b0;
      @(posedge clk_i);
    end
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [3:0] addr, input logic [63:0] data,
                                input logic [63:0] readback);
    logic [63:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    got = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== readback) report_mismatch("register readback", got, readback);
  endtask

  task automatic configure(input logic [62:0] start, input logic [15:0] interval);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    wait_drained();
    write_register(ADDR_CLOCK_START, {junk[63], start}, {1'b0, start});
    write_register(ADDR_SYNC_INTERVAL, {junk[63:16], interval}, {48'd0, interval});
    cfg.clock_start_ms   = start;
    cfg.sync_interval_ms = interval;
    settings_used++;
  endtask

  task automatic run_random_words(input int count);
    for (int i = 0; i < count; i++) send_word(gen_word());
  endtask

  task automatic test_directed_cases();
    send_word(mk_word(OP_TIME_QUERY, MAX63, '0, '1, 8'd0, 1'b0, 4'd0));
    send_word(mk_word(OP_DELAY_RESPONSE, 63'd10, '0, 64'd5, 8'd3, 1'b1, 4'd1));
    send_word(mk_word(OP_LEADER, 63'd20, '0, '0, UNSYNCED_LEVEL, 1'b1, 4'd0));
    send_word(mk_word(OP_LEADER, 63'd30, '0, '0, 8'd7, 1'b1, 4'd0));
    send_word(mk_word(OP_SYNC_START, 63'd40, 63'd45, '0, LEVEL_LIMIT, 1'b1, 4'd2));
    send_word(mk_word(OP_SYNC_START, 63'd50, 63'd55, '0, 8'd3, 1'b0, 4'd2));
    send_word(mk_word(OP_SYNC_START, 63'd1000, 63'd1010, 64'd900, 8'd253, 1'b1, 4'd15));
    send_word(mk_word(OP_SYNC_START, 63'd2000, 63'd2010, '0, 8'd3, 1'b1, 4'd1));
    send_word(mk_word(OP_DELAY_RESPONSE, 63'd1500, '0, 64'd1200, 8'd252, 1'b1, 4'd15));
    send_word(mk_word(OP_SYNC_START, 63'd2000, 63'd2010, '0, 8'd4, 1'b1, 4'd3));
    send_word(mk_word(OP_DELAY_RESPONSE, 63'd7010, '0, 64'd4013, 8'd4, 1'b1, 4'd3));
    send_word(mk_word(OP_TIME_QUERY, 63'd100, '0, '0, 8'd0, 1'b0, 4'd0));
    send_word(mk_word(OP_SYNC_START, 63'd20000, 63'd20005, '0, 8'd4, 1'b1, 4'd9));
    send_word(mk_word(OP_SYNC_START, 63'd20100, 63'd20105, '0, 8'd5, 1'b1, 4'd3));
    send_word(mk_word(OP_TIME_QUERY, 63'd500, '0, '0, 8'd0, 1'b0, 4'd0));
    send_word(mk_word(OP_SYNC_START, 63'd30000, 63'd30010, 64'd29990, 8'd0, 1'b1, 4'd0));
    send_word(mk_word(OP_DELAY_RESPONSE, 63'd35011, '0, 64'd30020, 8'd0, 1'b1, 4'd0));
    send_word(mk_word(OP_LEADER, 63'd40000, '0, '0, LEADER_LEVEL, 1'b1, 4'd0));
    send_word(mk_word(OP_SYNC_START, 63'd40100, 63'd40110, '0, 8'd3, 1'b1, 4'd4));
    send_word(mk_word(OP_TIME_QUERY, 63'd40200, '0, '0, 8'd0, 1'b0, 4'd0));
    send_word(mk_word(OP_LEADER, 63'd40300, '0, '0, UNSYNCED_LEVEL, 1'b1, 4'd0));
    send_word(mk_word(OP_SYNC_START, MAX63, MAX63, '1, 8'd0, 1'b1, 4'd0));
    send_word(mk_word(OP_DELAY_RESPONSE, MAX63, '0, 64'h8000_0000_0000_0000, 8'd0, 1'b1,
                      4'd0));
    send_word(mk_word(OP_TIME_QUERY, '0, '0, '0, 8'd0, 1'b0, 4'd0));
  endtask

  task automatic test_interval_minimum();
    configure('0, 16'd0);
    run_random_words(300);
  endtask

  task automatic test_settings_maximum();
    configure(MAX63, 16'hFFFF);
    run_random_words(300);
  endtask

  task automatic test_random_settings();
    logic [15:0] interval;
    for (int k = 0; k < 2; k++) begin
      interval = (k == 0) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(1, 8));
      configure(pick_time(), interval);
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
      run_random_words(150);
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      run_random_words(100);
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    configure(pick_time(), 16'd300);
    tx_gaps = 1'b0;
    hold_cycles = 300;
    run_random_words(120);
    wait_drained();
    tx_gaps = 1'b1;
    run_random_words(80);
  endtask

  task automatic test_default_interval();
    configure(pick_time(), SYNC_INTERVAL_RESET);
    run_random_words(150);
  endtask

  initial begin : watchdog
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** clock_sync_level_offset_engine: FAILED **");
    $finish;
  end

  initial begin : rx_holdoff
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        rx_hold = 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
        rx_hold = 1'b0;
      end
    end
  end

  initial begin : result_check
    int      stall_left;
    result_t want;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with no input pending", time_out_o, '0);
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) begin
            report_mismatch("status", 64'(status_o), 64'(want.status));
          end
          if (send_delay_request_o !== want.send_delay_request) begin
            report_mismatch("send_delay_request", 64'(send_delay_request_o),
                            64'(want.send_delay_request));
          end
          if (level_out_o !== want.level_out) begin
            report_mismatch("level_out", 64'(level_out_o), 64'(want.level_out));
          end
          if (time_out_o !== want.time_out) report_mismatch("time_out", time_out_o, want.time_out);
          if (offset_out_o !== want.offset_out) begin
            report_mismatch("offset_out", offset_out_o, want.offset_out);
          end
        end
        results_checked++;
        stall_left = rx_gaps ? $urandom_range(0, 7) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready_i <= (stall_left == 0) && !rx_hold;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_valid_i         = 1'b0;
    opcode_i           = OP_SYNC_START;
    now_ms_i           = '0;
    send_ms_i          = '0;
    remote_timestamp_i = '0;
    sender_level_i     = '0;
    peer_known_i       = 1'b0;
    peer_index_i       = '0;
    eng                  = '0;
    eng.node_level       = UNSYNCED_LEVEL;
    cfg.clock_start_ms   = '0;
    cfg.sync_interval_ms = SYNC_INTERVAL_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_interval_minimum();
    test_settings_maximum();
    test_random_settings();
    test_backpressure();
    test_default_interval();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch("result words never delivered", 64'(expected_results.size()), '0);
    end
    $display("Sent %0d words under %0d register settings; checked %0d result words.",
             words_sent, settings_used + 1, results_checked);
    $display("Sync starts accepted: %0d, rounds closed with a new offset: %0d.",
             syncs_accepted, rounds_closed);
    if (fail_count == 0) begin
      $display("** clock_sync_level_offset_engine: PASSED **");
    end else begin
      $display("** clock_sync_level_offset_engine: FAILED **");
    end
    $finish;
  end

endmodule
